### src/pgn_pkg.sv
`timescale 1ns / 1ps
package pgn_pkg;

  localparam int BODIES     = 2;
  localparam int BODY_W     = (BODIES > 1) ? $clog2(BODIES) : 1;
  localparam int FRAC_BITS  = 32;
  localparam int COEF_SHIFT = 60;
  localparam int NUM_PHASES = 9;

  typedef logic signed [63:0] s64_t;

  localparam s64_t S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam s64_t S64_MIN = 64'sh8000_0000_0000_0000;

  // PEFRL coefficients, 60 fraction bits
  localparam s64_t K_ZETA   = 64'sd205932413227106388;
  localparam s64_t K_LAMBDA = -64'sd244813463359671934;
  localparam s64_t K_CHI    = -64'sd76397862353831931;
  localparam s64_t K_ONE    = 64'sd1152921504606846976;
  localparam s64_t K_C1     = K_ONE / 2 - K_LAMBDA;
  localparam s64_t K_C2     = K_ONE - 2 * (K_CHI + K_ZETA);

  localparam logic [32:0] TS_RESET   = 33'd42949673;
  localparam logic [62:0] GC_RESET   = 63'd1 << FRAC_BITS;
  localparam logic [62:0] MASS_RESET = 63'd1 << FRAC_BITS;

  localparam logic [1:0] REG_TIME_STEP  = 2'd0;
  localparam logic [1:0] REG_GRAV_CONST = 2'd1;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  function automatic logic [63:0] mag64(input s64_t x);
    return x[63] ? (~x + 64'd1) : x;
  endfunction

  function automatic s64_t apply_sign(input logic [63:0] c, input logic neg);
    return neg ? s64_t'(~c + 64'd1) : s64_t'(c);
  endfunction

  function automatic s64_t sat_add(input s64_t a, input s64_t b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic s64_t sat_sub(input s64_t a, input s64_t b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  // signed floor of a magnitude product shifted right, saturated
  function automatic s64_t mul_post(input logic [127:0] p, input logic neg,
                                    input logic s60);
    logic [127:0]        sp;
    logic signed [127:0] sh;
    sp = neg ? (~p + 128'd1) : p;
    if (s60) sh = $signed(sp) >>> COEF_SHIFT;
    else     sh = $signed(sp) >>> FRAC_BITS;
    if ((&sh[127:63]) || !(|sh[127:63])) return sh[63:0];
    return sp[127] ? S64_MIN : S64_MAX;
  endfunction

  function automatic logic [127:0] shl_frac(input logic [63:0] x);
    return {64'd0, x} << FRAC_BITS;
  endfunction

  function automatic s64_t coef_of(input logic [3:0] phase);
    case (phase)
      4'd0, 4'd8: return K_ZETA;
      4'd1, 4'd7: return K_C1;
      4'd2, 4'd6: return K_CHI;
      4'd3, 4'd5: return K_LAMBDA;
      4'd4:       return K_C2;
      default:    return K_ZETA;
    endcase
  endfunction

endpackage

### src/pgn_mul.sv
`timescale 1ns / 1ps
module pgn_mul (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [63:0]  a_i,
  input  logic [63:0]  b_i,
  output logic         done_o,
  output logic [127:0] prod_o
);

  logic [63:0]  a_q, b_q, pp_q, pp_d;
  logic [127:0] acc_q;
  logic [1:0]   sh_q, sh_d;
  logic [2:0]   cnt_q;
  logic         busy_q, done_q;
  logic [31:0]  ma, mb;

  // one 32x32 partial product per cycle, low halves first
  always_comb begin
    case (cnt_q)
      3'd0: begin
        ma = a_q[31:0];  mb = b_q[31:0];  sh_d = 2'd0;
      end
      3'd1: begin
        ma = a_q[31:0];  mb = b_q[63:32]; sh_d = 2'd1;
      end
      3'd2: begin
        ma = a_q[63:32]; mb = b_q[31:0];  sh_d = 2'd1;
      end
      default: begin
        ma = a_q[63:32]; mb = b_q[63:32]; sh_d = 2'd2;
      end
    endcase
    pp_d = ma * mb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd4) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      pp_q <= pp_d;
      sh_q <= sh_d;
      if (cnt_q != 3'd0) acc_q <= acc_q + ({64'd0, pp_q} << {sh_q, 5'd0});
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

### src/pgn_div.sv
`timescale 1ns / 1ps
module pgn_div (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] num_i,
  input  logic [63:0]  den_i,
  output logic         done_o,
  output logic [63:0]  quo_o
);

  logic [63:0] rem_q, nlo_q, quo_q, den_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic        ovf;
  logic [64:0] r2, diff;
  logic        take;

  assign ovf  = (num_i[127:64] >= den_i);
  assign r2   = {rem_q, nlo_q[63]};
  assign diff = r2 - {1'b0, den_q};
  assign take = (r2 >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= '0;
        if (ovf) done_q <= 1'b1;
        else     busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[127:64];
      nlo_q <= num_i[63:0];
      den_q <= den_i;
      quo_q <= ovf ? 64'(pgn_pkg::S64_MAX) : 64'd0;
    end else if (busy_q) begin
      rem_q <= take ? diff[63:0] : r2[63:0];
      nlo_q <= {nlo_q[62:0], 1'b0};
      quo_q <= {quo_q[62:0], take};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q[63] ? 64'(pgn_pkg::S64_MAX) : quo_q;

endmodule

### src/pgn_sqrt.sv
`timescale 1ns / 1ps
module pgn_sqrt (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] rad_i,
  output logic         done_o,
  output logic [63:0]  root_o
);

  logic [127:0] rad_q;
  logic [64:0]  rem_q;
  logic [63:0]  root_q;
  logic [5:0]   cnt_q;
  logic         busy_q, done_q;
  logic [66:0]  r2, trial, diff;
  logic         take;

  assign r2    = {rem_q, rad_q[127:126]};
  assign trial = {1'b0, root_q, 2'b01};
  assign diff  = r2 - trial;
  assign take  = (r2 >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // one root bit per cycle from two radicand bits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[125:0], 2'b00};
      rem_q  <= take ? diff[64:0] : r2[64:0];
      root_q <= {root_q[62:0], take};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

### src/pefrl_gravity_nbody_step_core.sv
`timescale 1ns / 1ps
// Channel  | Handshake               | Payload
// ---------+-------------------------+----------------------------------------------
// in       | in_valid_i / in_ready_o  | mode, body_index, pos_*, vel_*, mass
// out      | out_valid_o / out_ready_i| out_index, new_pos_*, new_vel_*, fault, last
// cfg      | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// A load is written while idle and leaves in_ready_o high, so loads can follow back to
// back. A step runs nine phases (five drifts, four force passes each followed
// by a kick) on one shared 64x64 multiplier, one 128/64 divider and one
// square-root unit. The step ends with BODIES result transfers, one per body.
// Reset clears positions, velocities and forces, sets every mass to one and
// loads the default dt and G. in_ready_o and cfg_ready_o stay low while a step
// runs or its results are waiting; a stalled result holds.
module pefrl_gravity_nbody_step_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [3:0]  body_index_i,
  input  logic [63:0] pos_x_i,
  input  logic [63:0] pos_y_i,
  input  logic [63:0] pos_z_i,
  input  logic [63:0] vel_x_i,
  input  logic [63:0] vel_y_i,
  input  logic [63:0] vel_z_i,
  input  logic [62:0] mass_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  out_index_o,
  output logic [63:0] new_pos_x_o,
  output logic [63:0] new_pos_y_o,
  output logic [63:0] new_pos_z_o,
  output logic [63:0] new_vel_x_o,
  output logic [63:0] new_vel_y_o,
  output logic [63:0] new_vel_z_o,
  output logic        fault_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  localparam int BW = pgn_pkg::BODY_W;
  localparam int NB = pgn_pkg::BODIES;

  typedef enum logic [4:0] {
    S_IDLE, S_PHASE, S_HWAIT, S_UPD, S_UMUL, S_UDIV, S_UNEXT, S_UBODY,
    S_PRI, S_PRJ, S_PSQ, S_PSQW, S_PCHK, S_PSQRT, S_PGM, S_PGMM,
    S_PQ1, S_PQ2, S_PFM, S_PFMW, S_PFDW, S_PWI, S_PWJ, S_PNEXT,
    S_OLOAD, S_OWAIT
  } st_e;

  st_e state_q;

  // body store
  pgn_pkg::s64_t pos_q [3][NB];
  pgn_pkg::s64_t vel_q [3][NB];
  pgn_pkg::s64_t frc_q [3][NB];
  logic [62:0]   mass_q [NB];

  logic [32:0] ts_q;
  logic [62:0] gc_q;

  logic [3:0]    phase_q;
  logic          forces_done_q;
  logic          fault_q;
  logic [BW-1:0] body_q, peer_q, rsel;
  logic [1:0]    ax_q;
  pgn_pkg::s64_t h_q, t_q, r_q [3], f_q [3];
  logic [127:0]  d2_q;
  logic [63:0]   d_q, q2_q;
  logic [62:0]   mi_q, mj_q;

  // shared unit control
  logic          mul_start_q, mul_neg_q, mul_s60_q, mul_done;
  logic [63:0]   mul_a_q, mul_b_q;
  logic [127:0]  mul_prod;
  pgn_pkg::s64_t mul_res;
  logic          div_start_q, div_done;
  logic [127:0]  div_num_q;
  logic [63:0]   div_den_q, div_quo;
  logic          sqrt_start_q, sqrt_done;
  logic [127:0]  sqrt_rad_q;
  logic [63:0]   sqrt_root;

  pgn_pkg::s64_t coef;
  logic          is_kick;

  // output register
  logic          out_valid_q, last_q, ofault_q;
  logic [3:0]    oidx_q;
  pgn_pkg::s64_t opos_q [3], ovel_q [3];

  pgn_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start_q), .a_i(mul_a_q), .b_i(mul_b_q),
    .done_o(mul_done), .prod_o(mul_prod)
  );

  pgn_div u_div (
    .clk_i, .rst_ni, .start_i(div_start_q), .num_i(div_num_q), .den_i(div_den_q),
    .done_o(div_done), .quo_o(div_quo)
  );

  pgn_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sqrt_start_q), .rad_i(sqrt_rad_q),
    .done_o(sqrt_done), .root_o(sqrt_root)
  );

  // second body of a pair is read only in its own states
  assign rsel    = (state_q == S_PRJ || state_q == S_PWJ) ? peer_q : body_q;
  assign mul_res = pgn_pkg::mul_post(mul_prod, mul_neg_q, mul_s60_q);
  assign coef    = pgn_pkg::coef_of(phase_q);
  assign is_kick = phase_q[0];

  assign in_ready_o  = (state_q == S_IDLE);
  // hold register writes until no step is in flight
  assign cfg_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      for (int k = 0; k < 3; k++) begin
        for (int b = 0; b < NB; b++) begin
          pos_q[k][b] <= '0;
          vel_q[k][b] <= '0;
          frc_q[k][b] <= '0;
        end
        r_q[k]    <= '0;
        f_q[k]    <= '0;
        opos_q[k] <= '0;
        ovel_q[k] <= '0;
      end
      for (int b = 0; b < NB; b++) mass_q[b] <= pgn_pkg::MASS_RESET;
      ts_q          <= pgn_pkg::TS_RESET;
      gc_q          <= pgn_pkg::GC_RESET;
      phase_q       <= '0;
      forces_done_q <= 1'b0;
      fault_q       <= 1'b0;
      body_q        <= '0;
      peer_q        <= '0;
      ax_q          <= '0;
      h_q           <= '0;
      t_q           <= '0;
      d2_q          <= '0;
      d_q           <= '0;
      q2_q          <= '0;
      mi_q          <= '0;
      mj_q          <= '0;
      mul_start_q   <= 1'b0;
      mul_neg_q     <= 1'b0;
      mul_s60_q     <= 1'b0;
      mul_a_q       <= '0;
      mul_b_q       <= '0;
      div_start_q   <= 1'b0;
      div_num_q     <= '0;
      div_den_q     <= '0;
      sqrt_start_q  <= 1'b0;
      sqrt_rad_q    <= '0;
      out_valid_q   <= 1'b0;
      last_q        <= 1'b0;
      ofault_q      <= 1'b0;
      oidx_q        <= '0;
    end else begin
      mul_start_q  <= 1'b0;
      div_start_q  <= 1'b0;
      sqrt_start_q <= 1'b0;

      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          pgn_pkg::REG_TIME_STEP:  ts_q <= cfg_data_i[32:0];
          pgn_pkg::REG_GRAV_CONST: gc_q <= cfg_data_i[62:0];
          default: ;
        endcase
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (mode_i == pgn_pkg::MODE_LOAD) begin
              // drop loads aimed past the last body
              if ({1'b0, body_index_i} < 5'(NB)) begin
                pos_q[0][body_index_i[BW-1:0]] <= pos_x_i;
                pos_q[1][body_index_i[BW-1:0]] <= pos_y_i;
                pos_q[2][body_index_i[BW-1:0]] <= pos_z_i;
                vel_q[0][body_index_i[BW-1:0]] <= vel_x_i;
                vel_q[1][body_index_i[BW-1:0]] <= vel_y_i;
                vel_q[2][body_index_i[BW-1:0]] <= vel_z_i;
                mass_q[body_index_i[BW-1:0]]   <= mass_i;
              end
            end else begin
              phase_q       <= '0;
              forces_done_q <= 1'b0;
              fault_q       <= 1'b0;
              state_q       <= S_PHASE;
            end
          end
        end

        S_PHASE: begin
          if (phase_q == 4'(pgn_pkg::NUM_PHASES)) begin
            body_q  <= '0;
            state_q <= S_OLOAD;
          end else if (is_kick && !forces_done_q) begin
            // fresh force pass ahead of the kick
            for (int k = 0; k < 3; k++)
              for (int b = 0; b < NB; b++) frc_q[k][b] <= '0;
            body_q  <= '0;
            peer_q  <= BW'(1);
            state_q <= S_PRI;
          end else begin
            // sub-step size h = dt * coefficient
            mul_a_q     <= 64'(ts_q);
            mul_b_q     <= pgn_pkg::mag64(coef);
            mul_neg_q   <= coef[63];
            mul_s60_q   <= 1'b1;
            mul_start_q <= 1'b1;
            state_q     <= S_HWAIT;
          end
        end

        S_HWAIT: begin
          if (mul_done) begin
            h_q     <= mul_res;
            body_q  <= '0;
            ax_q    <= '0;
            state_q <= S_UPD;
          end
        end

        S_UPD: begin
          if (is_kick && mass_q[rsel] == 63'd0) begin
            state_q <= S_UBODY;
          end else begin
            if (is_kick) begin
              mul_a_q   <= pgn_pkg::mag64(frc_q[ax_q][rsel]);
              mul_neg_q <= frc_q[ax_q][rsel][63] ^ h_q[63];
            end else begin
              mul_a_q   <= pgn_pkg::mag64(vel_q[ax_q][rsel]);
              mul_neg_q <= vel_q[ax_q][rsel][63] ^ h_q[63];
            end
            mul_b_q     <= pgn_pkg::mag64(h_q);
            mul_s60_q   <= 1'b0;
            mul_start_q <= 1'b1;
            state_q     <= S_UMUL;
          end
        end

        S_UMUL: begin
          if (mul_done) begin
            if (is_kick) begin
              t_q         <= mul_res;
              div_num_q   <= pgn_pkg::shl_frac(pgn_pkg::mag64(mul_res));
              div_den_q   <= {1'b0, mass_q[rsel]};
              div_start_q <= 1'b1;
              state_q     <= S_UDIV;
            end else begin
              pos_q[ax_q][rsel] <= pgn_pkg::sat_add(pos_q[ax_q][rsel], mul_res);
              state_q           <= S_UNEXT;
            end
          end
        end

        S_UDIV: begin
          if (div_done) begin
            vel_q[ax_q][rsel] <= pgn_pkg::sat_add(vel_q[ax_q][rsel],
                                                  pgn_pkg::apply_sign(div_quo, t_q[63]));
            state_q <= S_UNEXT;
          end
        end

        S_UNEXT: begin
          if (ax_q == 2'd2) begin
            state_q <= S_UBODY;
          end else begin
            ax_q    <= ax_q + 2'd1;
            state_q <= S_UPD;
          end
        end

        S_UBODY: begin
          ax_q <= '0;
          if (body_q == BW'(NB - 1)) begin
            phase_q       <= phase_q + 4'd1;
            forces_done_q <= 1'b0;
            state_q       <= S_PHASE;
          end else begin
            body_q  <= body_q + BW'(1);
            state_q <= S_UPD;
          end
        end

        S_PRI: begin
          for (int k = 0; k < 3; k++) r_q[k] <= pos_q[k][rsel];
          mi_q    <= mass_q[rsel];
          state_q <= S_PRJ;
        end

        S_PRJ: begin
          // separation vector from body i to body j
          for (int k = 0; k < 3; k++) r_q[k] <= pgn_pkg::sat_sub(pos_q[k][rsel], r_q[k]);
          mj_q    <= mass_q[rsel];
          d2_q    <= '0;
          ax_q    <= '0;
          state_q <= S_PSQ;
        end

        S_PSQ: begin
          mul_a_q     <= pgn_pkg::mag64(r_q[ax_q]);
          mul_b_q     <= pgn_pkg::mag64(r_q[ax_q]);
          mul_neg_q   <= 1'b0;
          mul_s60_q   <= 1'b0;
          mul_start_q <= 1'b1;
          state_q     <= S_PSQW;
        end

        S_PSQW: begin
          if (mul_done) begin
            d2_q <= d2_q + mul_prod;
            if (ax_q == 2'd2) begin
              ax_q    <= '0;
              state_q <= S_PCHK;
            end else begin
              ax_q    <= ax_q + 2'd1;
              state_q <= S_PSQ;
            end
          end
        end

        S_PCHK: begin
          if (d2_q == 128'd0) begin
            // coincident pair: no force, flag the step
            fault_q <= 1'b1;
            state_q <= S_PNEXT;
          end else begin
            sqrt_rad_q   <= d2_q;
            sqrt_start_q <= 1'b1;
            state_q      <= S_PSQRT;
          end
        end

        S_PSQRT: begin
          if (sqrt_done) begin
            d_q         <= sqrt_root;
            mul_a_q     <= 64'(gc_q);
            mul_b_q     <= 64'(mi_q);
            mul_neg_q   <= 1'b0;
            mul_s60_q   <= 1'b0;
            mul_start_q <= 1'b1;
            state_q     <= S_PGM;
          end
        end

        S_PGM: begin
          if (mul_done) begin
            mul_a_q     <= pgn_pkg::mag64(mul_res);
            mul_b_q     <= 64'(mj_q);
            mul_neg_q   <= mul_res[63];
            mul_start_q <= 1'b1;
            state_q     <= S_PGMM;
          end
        end

        S_PGMM: begin
          if (mul_done) begin
            div_num_q   <= pgn_pkg::shl_frac(mul_res[63] ? 64'd0 : 64'(mul_res));
            div_den_q   <= d_q;
            div_start_q <= 1'b1;
            state_q     <= S_PQ1;
          end
        end

        S_PQ1: begin
          if (div_done) begin
            div_num_q   <= pgn_pkg::shl_frac(div_quo);
            div_start_q <= 1'b1;
            state_q     <= S_PQ2;
          end
        end

        S_PQ2: begin
          if (div_done) begin
            q2_q    <= div_quo;
            ax_q    <= '0;
            state_q <= S_PFM;
          end
        end

        S_PFM: begin
          mul_a_q     <= q2_q;
          mul_b_q     <= pgn_pkg::mag64(r_q[ax_q]);
          mul_neg_q   <= 1'b0;
          mul_s60_q   <= 1'b0;
          mul_start_q <= 1'b1;
          state_q     <= S_PFMW;
        end

        S_PFMW: begin
          if (mul_done) begin
            div_num_q   <= mul_prod;
            div_den_q   <= d_q;
            div_start_q <= 1'b1;
            state_q     <= S_PFDW;
          end
        end

        S_PFDW: begin
          if (div_done) begin
            f_q[ax_q] <= pgn_pkg::apply_sign(div_quo, r_q[ax_q][63]);
            if (ax_q == 2'd2) begin
              state_q <= S_PWI;
            end else begin
              ax_q    <= ax_q + 2'd1;
              state_q <= S_PFM;
            end
          end
        end

        S_PWI: begin
          for (int k = 0; k < 3; k++)
            frc_q[k][rsel] <= pgn_pkg::sat_add(frc_q[k][rsel], f_q[k]);
          state_q <= S_PWJ;
        end

        S_PWJ: begin
          for (int k = 0; k < 3; k++)
            frc_q[k][rsel] <= pgn_pkg::sat_sub(frc_q[k][rsel], f_q[k]);
          state_q <= S_PNEXT;
        end

        S_PNEXT: begin
          if (peer_q == BW'(NB - 1)) begin
            if (body_q == BW'(NB - 2)) begin
              forces_done_q <= 1'b1;
              state_q       <= S_PHASE;
            end else begin
              body_q  <= body_q + BW'(1);
              peer_q  <= body_q + BW'(1) + BW'(1);
              state_q <= S_PRI;
            end
          end else begin
            peer_q  <= peer_q + BW'(1);
            state_q <= S_PRI;
          end
        end

        S_OLOAD: begin
          for (int k = 0; k < 3; k++) begin
            opos_q[k] <= pos_q[k][rsel];
            ovel_q[k] <= vel_q[k][rsel];
          end
          oidx_q      <= 4'(body_q);
          ofault_q    <= fault_q;
          last_q      <= (body_q == BW'(NB - 1));
          out_valid_q <= 1'b1;
          state_q     <= S_OWAIT;
        end

        S_OWAIT: begin
          // hold the result until the transfer
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            if (last_q) begin
              state_q <= S_IDLE;
            end else begin
              body_q  <= body_q + BW'(1);
              state_q <= S_OLOAD;
            end
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_index_o = oidx_q;
  assign new_pos_x_o = opos_q[0];
  assign new_pos_y_o = opos_q[1];
  assign new_pos_z_o = opos_q[2];
  assign new_vel_x_o = ovel_q[0];
  assign new_vel_y_o = ovel_q[1];
  assign new_vel_z_o = ovel_q[2];
  assign fault_o     = ofault_q;
  assign last_o      = last_q;

endmodule
